// ----- src/sliding_window_arq_sender_assert.svh -----
// Assertion macros for the sliding-window ARQ sender.
`ifndef SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SWA_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SWA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define SWA_ASSERT_IMPL(label, clk, rst_n, prop)
`define SWA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/swa_pkg.sv -----
// Shared types and constants of the sliding-window ARQ sender.
package swa_pkg;
    localparam int CHUNK_BYTES = 1024;
    localparam int SEQ_BITS    = 16;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ACK   = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_GBN     = 2'd2;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [26:0] byte_count;
        logic        final_buffer;
        logic [15:0] ack_sequence;
        logic        ack_is_nak;
        logic        ack_corrupt;
    } swa_req_t;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] frame_sequence;
        logic [10:0] payload_length;
        logic        end_of_transfer;
        logic        is_retransmit;
        logic [16:0] window_base;
        logic        buffer_done;
        logic        last_item;
    } swa_rsp_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } swa_cfg_t;
endpackage

// ----- src/swa_if.sv -----
// Valid/ready channel interfaces of the sliding-window ARQ sender.
interface swa_req_if import swa_pkg::*; ();
    logic     valid;
    logic     ready;
    swa_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swa_rsp_if import swa_pkg::*; ();
    logic     valid;
    logic     ready;
    swa_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swa_cfg_if import swa_pkg::*; ();
    logic     valid;
    logic     ready;
    swa_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/sliding_window_arq_sender.sv -----
// Channel      | Dir | Payload
// req          | in  | req_type, byte_count, final_buffer, ack_sequence, ack_is_nak, ack_corrupt
// rsp          | out | item_kind, frame_sequence, payload_length, end_of_transfer, ...
// cfg          | in  | index, data (window_size, timeout_ticks, go_back_n)
// With W the effective window, a request passes through accept, the slide of acked
// slots off the base, a send pass over the W slots, a timeout pass that reads each
// slot's sent time from the RAM and then compares it, and the status result.
// Each frame result holds its pass until taken; a resend adds an issue state.
// The status result blocks the next request until taken. Reset clears flags,
// no clearing pass. Sent times live in a ring RAM indexed by absolute slot.
module sliding_window_arq_sender
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW  = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    swa_req_if.sink   req,
    swa_rsp_if.source rsp,
    swa_cfg_if.sink   cfg
);
    `include "sliding_window_arq_sender_assert.svh"

    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int CB = $clog2(CHUNK_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLIDE = 3'd1;
    localparam logic [2:0] ST_SEND  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_TO    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_STAT  = 3'd6;

    logic [2:0]  state_reg;
    logic [5:0]  win_reg;
    logic [15:0] tmo_reg;
    logic        gbn_reg;
    logic [16:0] base_reg;
    logic [16:0] fc_reg;
    logic [26:0] bytes_reg;
    logic        final_reg;
    logic [31:0] tick_reg;
    logic [MAX_WINDOW-1:0] acked_reg, sent_reg, force_reg, fresh_reg;
    logic [CW-1:0] idx_reg;
    logic        gbn_go_reg;
    logic [CW-1:0] weff;
    swa_rsp_t    out_reg;
    logic        out_valid_reg;

    logic        ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;

    always_comb
    begin
        if (win_reg == 6'd0)
            weff = CW'(1);
        else if (32'(win_reg) > 32'(MAX_WINDOW))
            weff = CW'(MAX_WINDOW);
        else
            weff = CW'(win_reg);
    end

    logic [SW-1:0] slot;
    logic [16:0]   seq;
    logic          in_range;
    logic [26:0]   off_bytes;
    logic [26:0]   left;
    logic [10:0]   plen;
    logic          expired;
    logic [31:0]   age;

    assign slot     = idx_reg[SW-1:0];
    assign seq      = base_reg + 17'(idx_reg);
    assign in_range = (idx_reg < weff) && (seq < fc_reg);
    assign off_bytes = 27'(seq) << CB;
    assign left     = bytes_reg - off_bytes;
    always_comb
    begin
        if ((27'(seq) >> (27 - CB)) != 27'd0 || off_bytes >= bytes_reg)
            plen = 11'd0;
        else if (left > 27'(CHUNK_BYTES))
            plen = 11'(CHUNK_BYTES);
        else
            plen = 11'(left);
    end
    assign age     = tick_reg - ram_rdata;
    assign expired = force_reg[slot] || (age > 32'(tmo_reg));

    assign ram_raddr = SW'(base_reg + 17'(idx_reg));
    assign ram_waddr = ram_raddr;
    assign ram_we    = (state_reg == ST_SEND && in_range && !sent_reg[slot] && !out_valid_reg)
                    || (state_reg == ST_OUT && !out_valid_reg);

    swa_ram #(.WIDTH(32), .DEPTH(1 << SW)) u_time (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(tick_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    logic [16:0] ack_off;
    assign ack_off = {1'b0, req.data.ack_sequence} - base_reg;

    logic [16:0] fc_calc;
    logic [26:0] fc_raw;
    assign fc_raw  = (req.data.byte_count >> CB) + 27'(|(req.data.byte_count & 27'(CHUNK_BYTES - 1)));
    assign fc_calc = (fc_raw > 27'(1 << SEQ_BITS)) ? 17'(1 << SEQ_BITS) : 17'(fc_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg <= 6'd1; tmo_reg <= 16'd100; gbn_reg <= 1'b0;
            base_reg <= '0; fc_reg <= '0; bytes_reg <= '0; final_reg <= 1'b0;
            tick_reg <= '0; acked_reg <= '0; sent_reg <= '0; force_reg <= '0;
            fresh_reg <= '0; idx_reg <= '0; gbn_go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    CFG_WINDOW:  win_reg <= cfg.data.data[5:0];
                    CFG_TIMEOUT: tmo_reg <= cfg.data.data;
                    CFG_GBN:     gbn_reg <= cfg.data.data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        state_reg <= ST_SLIDE;
                        idx_reg <= '0;
                        case (req.data.req_type)
                            REQ_START:
                            begin
                                bytes_reg <= req.data.byte_count;
                                final_reg <= req.data.final_buffer;
                                fc_reg <= fc_calc;
                                base_reg <= '0;
                                acked_reg <= '0; sent_reg <= '0; force_reg <= '0;
                            end
                            REQ_ACK:
                            begin
                                if (!req.data.ack_corrupt && {1'b0, req.data.ack_sequence} >= base_reg
                                    && ack_off < 17'(weff) && {1'b0, req.data.ack_sequence} < fc_reg)
                                begin
                                    if (req.data.ack_is_nak)
                                        force_reg[ack_off[SW-1:0]] <= 1'b1;
                                    else
                                        acked_reg[ack_off[SW-1:0]] <= 1'b1;
                                end
                            end
                            REQ_TICK: tick_reg <= tick_reg + 32'd1;
                            default: ;
                        endcase
                    end
                end
                ST_SLIDE:
                begin
                    // one slot per cycle off the base while acked, at most one window
                    if (acked_reg[0] && idx_reg < weff)
                    begin
                        acked_reg <= acked_reg >> 1;
                        sent_reg  <= sent_reg >> 1;
                        force_reg <= force_reg >> 1;
                        base_reg  <= base_reg + 17'd1;
                        idx_reg   <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_SEND;
                        idx_reg <= '0;
                        fresh_reg <= '0;
                    end
                end
                ST_SEND:
                begin
                    if (!out_valid_reg)
                    begin
                        if (in_range && !sent_reg[slot])
                        begin
                            out_reg <= '{KIND_FRAME, seq[15:0], plen,
                                final_reg && (seq + 17'd1 == fc_reg), 1'b0, 17'd0, 1'b0, 1'b0};
                            out_valid_reg <= 1'b1;
                            sent_reg[slot] <= 1'b1;
                            force_reg[slot] <= 1'b0;
                            fresh_reg[slot] <= 1'b1;
                        end
                        if (idx_reg + CW'(1) >= weff)
                        begin
                            idx_reg <= '0;
                            state_reg <= ST_RD;
                            gbn_go_reg <= 1'b0;
                        end
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_RD: state_reg <= ST_TO;
                ST_TO:
                begin
                    if (!gbn_reg)
                    begin
                        if (in_range && !fresh_reg[slot] && !acked_reg[slot] && expired)
                            state_reg <= ST_OUT;
                        else if (idx_reg + CW'(1) >= weff)
                            state_reg <= ST_STAT;
                        else
                        begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                    else if (idx_reg == '0 && !gbn_go_reg)
                    begin
                        if (in_range && !fresh_reg[0] && !acked_reg[0] && expired)
                        begin
                            gbn_go_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_STAT;
                    end
                    else if (in_range && !fresh_reg[slot])
                        state_reg <= ST_OUT;
                    else if (idx_reg + CW'(1) >= weff)
                        state_reg <= ST_STAT;
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{KIND_FRAME, seq[15:0], plen,
                            final_reg && (seq + 17'd1 == fc_reg), 1'b1, 17'd0, 1'b0, 1'b0};
                        out_valid_reg <= 1'b1;
                        sent_reg[slot] <= 1'b1;
                        force_reg[slot] <= 1'b0;
                        if (idx_reg + CW'(1) >= weff)
                            state_reg <= ST_STAT;
                        else
                        begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_STAT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{KIND_STATUS, 16'd0, 11'd0, 1'b0, 1'b0, base_reg,
                            base_reg >= fc_reg, 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SWA_ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid_reg && !rsp.ready) |=> out_valid_reg)
    `SWA_ASSERT_NEVER(a_busy_ready, clk, rst_n, req.ready && state_reg != ST_IDLE)
    `SWA_ASSERT_IMPL(a_stat_last, clk, rst_n,
        (out_valid_reg && out_reg.item_kind == KIND_STATUS) |-> out_reg.last_item)
endmodule

// ----- src/swa_ram.sv -----
// Generic single-port-write RAM with registered read.
module swa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sim/tb_sliding_window_arq_sender.sv -----
// Testbench of the sliding-window ARQ sender: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module tb_sliding_window_arq_sender;
    import swa_pkg::*;

    localparam int WIN_MAX     = 32;
    localparam int CHUNK       = 1024;
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;

    swa_req_if req_if ();
    swa_rsp_if rsp_if ();
    swa_cfg_if cfg_if ();

    sliding_window_arq_sender u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // predictor copy of the sender
    logic [5:0]  win_reg;
    logic [15:0] tmo_reg;
    logic        gbn_reg;
    logic [16:0] base_seq;
    logic [16:0] frames_total;
    logic [26:0] buf_bytes;
    logic        buf_final;
    bit          acked [WIN_MAX];
    bit          sent [WIN_MAX];
    bit          nak_pending [WIN_MAX];
    logic [31:0] sent_at [WIN_MAX];
    logic [31:0] now_ticks;

    swa_rsp_t expected_items [$];
    int       errors;
    bit       idle_en;
    int       stall_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_win();
        if (win_reg == 0) return 1;
        if (win_reg > WIN_MAX) return WIN_MAX;
        return int'(win_reg);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WIN_MAX; i++)
        begin
            acked[i] = 0;
            sent[i] = 0;
            nak_pending[i] = 0;
            sent_at[i] = '0;
        end
    endfunction

    function automatic void emit_frame(int slot, bit rtx);
        swa_rsp_t    f;
        longint      seq;
        longint      off;
        longint      len;
        seq = longint'(base_seq) + slot;
        off = seq * CHUNK;
        len = 0;
        if (off < longint'(buf_bytes))
        begin
            len = longint'(buf_bytes) - off;
            if (len > CHUNK) len = CHUNK;
        end
        f = '0;
        f.item_kind = KIND_FRAME;
        f.frame_sequence = seq[15:0];
        f.payload_length = len[10:0];
        f.end_of_transfer = buf_final && (seq + 1 == longint'(frames_total));
        f.is_retransmit = rtx;
        expected_items.push_back(f);
        sent[slot] = 1;
        sent_at[slot] = now_ticks;
        nak_pending[slot] = 0;
    endfunction

    function automatic bit timed_out(int slot);
        logic [31:0] age;
        age = now_ticks - sent_at[slot];
        return nak_pending[slot] || (age > {16'd0, tmo_reg});
    endfunction

    function automatic void predict_request(swa_req_t r);
        int       w;
        int       shift;
        bit       fresh [WIN_MAX];
        longint   fc;
        swa_rsp_t st;
        w = eff_win();
        if (r.req_type == REQ_START)
        begin
            fc = (longint'(r.byte_count) + CHUNK - 1) / CHUNK;
            if (fc > 65536) fc = 65536;
            buf_bytes = r.byte_count;
            frames_total = fc[16:0];
            buf_final = r.final_buffer;
            base_seq = '0;
            clear_window();
        end
        else if (r.req_type == REQ_ACK)
        begin
            if (!r.ack_corrupt && {1'b0, r.ack_sequence} >= base_seq &&
                longint'(r.ack_sequence) < longint'(base_seq) + w &&
                {1'b0, r.ack_sequence} < frames_total)
            begin
                if (!r.ack_is_nak) acked[r.ack_sequence - base_seq] = 1;
                else nak_pending[r.ack_sequence - base_seq] = 1;
            end
        end
        else if (r.req_type == REQ_TICK)
            now_ticks = now_ticks + 1;

        shift = 0;
        while (shift < w && acked[shift]) shift++;
        if (shift > 0)
        begin
            for (int i = 0; i < WIN_MAX; i++)
            begin
                if (i + shift < WIN_MAX)
                begin
                    acked[i] = acked[i + shift];
                    sent[i] = sent[i + shift];
                    nak_pending[i] = nak_pending[i + shift];
                    sent_at[i] = sent_at[i + shift];
                end
                else
                begin
                    acked[i] = 0;
                    sent[i] = 0;
                    nak_pending[i] = 0;
                    sent_at[i] = '0;
                end
            end
            base_seq = base_seq + shift;
        end

        for (int i = 0; i < WIN_MAX; i++) fresh[i] = 0;
        for (int i = 0; i < w; i++)
        begin
            if (longint'(base_seq) + i < longint'(frames_total) && !sent[i])
            begin
                emit_frame(i, 1'b0);
                fresh[i] = 1;
            end
        end

        if (!gbn_reg)
        begin
            for (int i = 0; i < w; i++)
                if (longint'(base_seq) + i < longint'(frames_total) && !fresh[i] &&
                    !acked[i] && timed_out(i))
                    emit_frame(i, 1'b1);
        end
        else if (base_seq < frames_total && !fresh[0] && !acked[0] && timed_out(0))
        begin
            for (int i = 0; i < w; i++)
                if (longint'(base_seq) + i < longint'(frames_total) && !fresh[i])
                    emit_frame(i, 1'b1);
        end

        st = '0;
        st.item_kind = KIND_STATUS;
        st.window_base = base_seq;
        st.buffer_done = base_seq >= frames_total;
        st.last_item = 1'b1;
        expected_items.push_back(st);
    endfunction

    function automatic swa_req_t mk_req(logic [1:0] kind, logic [26:0] bytes, logic fin,
                                        logic [15:0] seq, logic nak, logic bad);
        swa_req_t r;
        r.req_type = kind;
        r.byte_count = bytes;
        r.final_buffer = fin;
        r.ack_sequence = seq;
        r.ack_is_nak = nak;
        r.ack_corrupt = bad;
        return r;
    endfunction

    task automatic send_req(input swa_req_t r);
        while (idle_en && $urandom_range(99) < 38)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge clk); while (!req_if.ready);
        predict_request(r);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: idx, data: val};
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == CFG_WINDOW) win_reg = val[5:0];
        else if (idx == CFG_TIMEOUT) tmo_reg = val;
        else if (idx == CFG_GBN) gbn_reg = val[0];
    endtask

    task automatic set_config(input logic [15:0] w, input logic [15:0] t, input logic g);
        drain();
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_GBN, {15'd0, g});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= idle_en ? ($urandom_range(99) >= 38) : 1'b1;
    end

    always @(posedge clk)
    begin
        swa_rsp_t got;
        swa_rsp_t want;
        if (rsp_if.valid && rsp_if.ready && rst_n)
        begin
            got = rsp_if.data;
            if (expected_items.size() == 0)
                report($sformatf("unexpected result %h", got));
            else
            begin
                want = expected_items.pop_front();
                if (got.item_kind !== want.item_kind)
                    report($sformatf("item_kind %0d want %0d", got.item_kind, want.item_kind));
                if (got.frame_sequence !== want.frame_sequence)
                    report($sformatf("frame_sequence %0d want %0d",
                                     got.frame_sequence, want.frame_sequence));
                if (got.payload_length !== want.payload_length)
                    report($sformatf("payload_length %0d want %0d",
                                     got.payload_length, want.payload_length));
                if (got.end_of_transfer !== want.end_of_transfer)
                    report($sformatf("end_of_transfer %0d want %0d",
                                     got.end_of_transfer, want.end_of_transfer));
                if (got.is_retransmit !== want.is_retransmit)
                    report($sformatf("is_retransmit %0d want %0d",
                                     got.is_retransmit, want.is_retransmit));
                if (got.window_base !== want.window_base)
                    report($sformatf("window_base %0d want %0d",
                                     got.window_base, want.window_base));
                if (got.buffer_done !== want.buffer_done)
                    report($sformatf("buffer_done %0d want %0d",
                                     got.buffer_done, want.buffer_done));
                if (got.last_item !== want.last_item)
                    report($sformatf("last_item %0d want %0d", got.last_item, want.last_item));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_defaults();
        send_req(mk_req(REQ_START, 27'd2500, 1'b1, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd1, 1'b1, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd1, 1'b0, 1'b1));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd9, 1'b0, 1'b0));
        send_req(mk_req(2'd3, '0, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd1, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd2, 1'b0, 1'b0));
    endtask

    task automatic test_window_limits();
        set_config(16'd63, 16'd0, 1'b0);
        send_req(mk_req(REQ_START, 27'h7FFFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        send_req(mk_req(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd31, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd32, 1'b0, 1'b0));
        set_config(16'd0, 16'hFFFF, 1'b0);
        send_req(mk_req(REQ_START, 27'd0, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_START, 27'd1, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0));
    endtask

    task automatic test_go_back_n();
        set_config(16'd4, 16'd1, 1'b1);
        send_req(mk_req(REQ_START, 27'd5000, 1'b1, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd2, 1'b0, 1'b0));
        send_req(mk_req(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd0, 1'b1, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd0, 1'b0, 1'b0));
        send_req(mk_req(REQ_ACK, '0, 1'b0, 16'd1, 1'b0, 1'b0));
    endtask

    task automatic test_random(input int n_items);
        int          pick;
        int          w;
        logic [26:0] bytes;
        logic [15:0] seq;
        for (int k = 0; k < n_items; k++)
        begin
            w = eff_win();
            pick = $urandom_range(99);
            if (base_seq >= frames_total || pick < 4)
            begin
                bytes = ($urandom_range(19) == 0) ? 27'($urandom)
                                                  : 27'($urandom_range(20000));
                send_req(mk_req(REQ_START, bytes, 1'($urandom), 16'($urandom),
                                1'($urandom), 1'($urandom)));
            end
            else if (pick < 54)
            begin
                seq = 16'(base_seq + $urandom_range(w - 1));
                send_req(mk_req(REQ_ACK, 27'($urandom), 1'($urandom), seq, 1'b0, 1'b0));
            end
            else if (pick < 62)
            begin
                seq = 16'(base_seq + $urandom_range(w - 1));
                send_req(mk_req(REQ_ACK, '0, 1'b0, seq, 1'b1, 1'b0));
            end
            else if (pick < 88)
                send_req(mk_req(REQ_TICK, 27'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b0));
            else if (pick < 94)
                send_req(mk_req(REQ_ACK, '0, 1'b0, 16'($urandom), 1'($urandom),
                                1'($urandom)));
            else if (pick < 97)
                send_req(mk_req(REQ_ACK, '0, 1'b0, 16'(base_seq), 1'b0, 1'b1));
            else
                send_req(mk_req(2'd3, 27'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b0));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        errors = 0;
        idle_en = 1;
        win_reg = 6'd1;
        tmo_reg = 16'd100;
        gbn_reg = 1'b0;
        base_seq = '0;
        frames_total = '0;
        buf_bytes = '0;
        buf_final = 1'b0;
        now_ticks = '0;
        clear_window();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_window_limits();
        test_go_back_n();

        set_config(16'd8, 16'd3, 1'b0);
        test_random(30);
        set_config(16'd32, 16'd6, 1'b1);
        idle_en = 0;
        test_random(25);
        set_config(16'd1, 16'd2, 1'b0);
        idle_en = 1;
        test_random(25);
        set_config(16'd5, 16'd0, 1'b1);
        test_random(30);

        drain();
        repeat (110) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
